// ===== rtl/ycbcr_to_rgb_with_gain_assert.svh =====
// Assertion macros shared by the checker of the color converter.
`ifndef YCBCR_TO_RGB_WITH_GAIN_ASSERT_SVH
`define YCBCR_TO_RGB_WITH_GAIN_ASSERT_SVH

// The consequent must hold a fixed number of cycles after the antecedent.
`define YCG_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (ante) |-> ##dly (cons)) else $error(msg);

// The antecedent must have held a fixed number of cycles before the consequent.
`define YCG_ASSERT_PAST(lbl, clk, rst_n, cons, ante, dly, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (cons) |-> $past(ante, dly)) else $error(msg);

`endif

// ===== rtl/ycg_pkg.sv =====
// Shared types and constants of the YCbCr to RGB converter with gain.
package ycg_pkg;

  localparam int unsigned CH_W       = 8;
  localparam int unsigned GAIN_W     = 12;
  localparam int unsigned GAIN_FRAC  = 8;
  localparam int unsigned LATENCY    = 4;
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);
  localparam logic [CH_W-1:0]   CH_MAX     = 8'd255;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

endpackage

// ===== rtl/ycg_matrix.sv =====
// Two-stage Q14 color matrix: chroma products, then sums with clamping.
module ycg_matrix (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [7:0]               luma_i,
  input  logic [7:0]               chroma_blue_i,
  input  logic [7:0]               chroma_red_i,
  output logic                     valid_o,
  output ycg_pkg::rgb_t            pix_o
);
  import ycg_pkg::*;

  typedef logic signed [24:0] acc_t;

  localparam acc_t K_R_CR = acc_t'(22972);
  localparam acc_t K_G_CB = acc_t'(5662);
  localparam acc_t K_G_CR = acc_t'(11706);
  localparam acc_t K_B_CB = acc_t'(29016);
  localparam int unsigned Q_SHIFT = 14;

  function automatic logic [CH_W-1:0] to_channel(input acc_t acc);
    logic [10:0] v;
    v = acc[Q_SHIFT +: 11];
    if (acc[24]) begin
      return '0;
    end else if (v > 11'(CH_MAX)) begin
      return CH_MAX;
    end else begin
      return v[CH_W-1:0];
    end
  endfunction

  logic signed [7:0] cb_s, cr_s;
  logic       s1_valid_q;
  logic [7:0] s1_luma_q;
  acc_t       s1_r_q, s1_gb_q, s1_gr_q, s1_b_q;
  acc_t       ys, sum_r, sum_g, sum_b;
  logic       s2_valid_q;
  rgb_t       s2_pix_q;

  assign cb_s = {~chroma_blue_i[7], chroma_blue_i[6:0]};
  assign cr_s = {~chroma_red_i[7], chroma_red_i[6:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_luma_q <= luma_i;
    s1_r_q    <= K_R_CR * acc_t'(cr_s);
    s1_gb_q   <= K_G_CB * acc_t'(cb_s);
    s1_gr_q   <= K_G_CR * acc_t'(cr_s);
    s1_b_q    <= K_B_CB * acc_t'(cb_s);
  end

  assign ys    = acc_t'({s1_luma_q, 14'b0});
  assign sum_r = ys + s1_r_q;
  assign sum_g = ys - s1_gb_q - s1_gr_q;
  assign sum_b = ys + s1_b_q;

  always_ff @(posedge clk_i) begin
    s2_pix_q.red   <= to_channel(sum_r);
    s2_pix_q.green <= to_channel(sum_g);
    s2_pix_q.blue  <= to_channel(sum_b);
  end

  assign valid_o = s2_valid_q;
  assign pix_o   = s2_pix_q;

endmodule

// ===== rtl/ycg_gain.sv =====
// Two-stage channel gain: products with the gain, then shift and saturation.
module ycg_gain (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  ycg_pkg::rgb_t               pix_i,
  input  logic [ycg_pkg::GAIN_W-1:0]  gain_i,
  output logic                        valid_o,
  output ycg_pkg::rgb_t               pix_o
);
  import ycg_pkg::*;

  localparam int unsigned PROD_W = CH_W + GAIN_W;
  localparam int unsigned SHR_W  = PROD_W - GAIN_FRAC;

  function automatic logic [CH_W-1:0] saturate(input logic [PROD_W-1:0] p);
    logic [SHR_W-1:0] v;
    v = p[PROD_W-1:GAIN_FRAC];
    if (v > SHR_W'(CH_MAX)) begin
      return CH_MAX;
    end else begin
      return v[CH_W-1:0];
    end
  endfunction

  logic              s3_valid_q, s4_valid_q;
  logic [PROD_W-1:0] s3_r_q, s3_g_q, s3_b_q;
  rgb_t              s4_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= valid_i;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_r_q <= PROD_W'(pix_i.red)   * PROD_W'(gain_i);
    s3_g_q <= PROD_W'(pix_i.green) * PROD_W'(gain_i);
    s3_b_q <= PROD_W'(pix_i.blue)  * PROD_W'(gain_i);
  end

  always_ff @(posedge clk_i) begin
    s4_pix_q.red   <= saturate(s3_r_q);
    s4_pix_q.green <= saturate(s3_g_q);
    s4_pix_q.blue  <= saturate(s3_b_q);
  end

  assign valid_o = s4_valid_q;
  assign pix_o   = s4_pix_q;

endmodule

// ===== rtl/ycbcr_to_rgb_with_gain.sv =====
// Top level of the pipelined YCbCr to RGB converter with channel gain.
// The block takes one pixel per clock and never raises busy_o. A pixel given
// with start_i shows up as one beat on red_o, green_o and blue_o, marked by
// done_o, after passing the four register stages of the color matrix and the
// gain multipliers. Results cannot be held off, so the receiver must take
// every beat. The gain register is written through cfg_we_i and cfg_wdata_i,
// resets to unity and applies to every channel of every pixel; the user must
// write it only while no pixel is in flight, which the block does not enforce.
module ycbcr_to_rgb_with_gain (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [7:0]                  luma_i,
  input  logic [7:0]                  chroma_blue_i,
  input  logic [7:0]                  chroma_red_i,
  input  logic                        cfg_we_i,
  input  logic [ycg_pkg::GAIN_W-1:0]  cfg_wdata_i,
  output logic                        done_o,
  output logic [7:0]                  red_o,
  output logic [7:0]                  green_o,
  output logic [7:0]                  blue_o
);
  import ycg_pkg::*;

  logic [GAIN_W-1:0] gain_q;
  logic              mid_valid;
  rgb_t              mid_pix;
  rgb_t              out_pix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (cfg_we_i) begin
      gain_q <= cfg_wdata_i;
    end
  end

  assign busy_o = 1'b0;

  ycg_matrix u_matrix (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (start_i & ~busy_o),
    .luma_i        (luma_i),
    .chroma_blue_i (chroma_blue_i),
    .chroma_red_i  (chroma_red_i),
    .valid_o       (mid_valid),
    .pix_o         (mid_pix)
  );

  ycg_gain u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mid_valid),
    .pix_i   (mid_pix),
    .gain_i  (gain_q),
    .valid_o (done_o),
    .pix_o   (out_pix)
  );

  assign red_o   = out_pix.red;
  assign green_o = out_pix.green;
  assign blue_o  = out_pix.blue;

endmodule

// ===== rtl/ycg_checker.sv =====
// Port-level checker of the color converter and its bind to the top level.
`include "ycbcr_to_rgb_with_gain_assert.svh"

module ycg_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_i,
  input logic [7:0] chroma_blue_i,
  input logic [7:0] chroma_red_i,
  input logic       done_i,
  input logic [7:0] red_i,
  input logic [7:0] green_i,
  input logic [7:0] blue_i
);
  import ycg_pkg::*;

  `YCG_ASSERT_DLY(a_done_after_start, clk_i, rst_ni, start_i && !busy_i, LATENCY, done_i, "accepted pixel gave no result beat")
  `YCG_ASSERT_PAST(a_done_has_start, clk_i, rst_ni, done_i, start_i && !busy_i, LATENCY, "result beat without an accepted pixel")
  `YCG_ASSERT_DLY(a_gray_stays_gray, clk_i, rst_ni, start_i && !busy_i && chroma_blue_i == 8'd128 && chroma_red_i == 8'd128, LATENCY, red_i == green_i && green_i == blue_i, "neutral chroma gave a colored result")
  `YCG_ASSERT_DLY(a_never_busy, clk_i, rst_ni, 1'b1, 0, !busy_i, "busy raised by a stall-free pipeline")

endmodule

bind ycbcr_to_rgb_with_gain ycg_checker u_ycg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_i        (busy_o),
  .chroma_blue_i (chroma_blue_i),
  .chroma_red_i  (chroma_red_i),
  .done_i        (done_o),
  .red_i         (red_o),
  .green_i       (green_o),
  .blue_i        (blue_o)
);
